/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define KMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define KMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/kmc_pkg.sv */
// shared constants and types of the k-means clustering block
`default_nettype none
package kmc_pkg;
  localparam int MAX_POINTS   = 4096;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int CNT_W        = PT_AW + 1;
  localparam int MAX_CLUSTERS = 16;
  localparam int CL_AW        = $clog2(MAX_CLUSTERS);
  localparam int K_W          = CL_AW + 1;
  localparam int COORD_W      = 16;
  localparam int SUM_W        = COORD_W + CNT_W;
  localparam int MAG_W        = SUM_W - 1;
  localparam int SQ_W         = 2 * (COORD_W + 1);
  localparam int DIST_W       = SQ_W + 1;
  localparam int RND_W        = 16;
  localparam int CFG_W        = 16;
  localparam int CHANGE_SHIFT = 10;

  // configuration register indexes
  localparam logic CFG_CLUSTER_COUNT = 1'b0;
  localparam logic CFG_MAX_ROUNDS    = 1'b1;

  // divider request and response
  typedef struct packed {
    logic                      start;
    logic signed [SUM_W-1:0]   num_x;
    logic signed [SUM_W-1:0]   num_y;
    logic [CNT_W-1:0]          den;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
  } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/kmc_div.sv */
// shared restoring divider for centroid x and y, truncating toward zero
`default_nettype none
module kmc_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kmc_pkg::div_req_t req,
  output kmc_pkg::div_rsp_t      rsp
);
  localparam int MW = kmc_pkg::MAG_W;
  localparam int DW = kmc_pkg::CNT_W;
  localparam int CW = $clog2(MW);

  logic          run_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] qx_r, qy_r;
  logic [DW-1:0] rx_r, ry_r, den_r;
  logic          negx_r, negy_r;

  logic [DW:0]   tx, ty, dx, dy;
  logic [MW-1:0] magx, magy, outx, outy;

  // magnitudes of the dividends
  always_comb begin
    magx = req.num_x[kmc_pkg::SUM_W-1] ? MW'(-req.num_x) : MW'(req.num_x);
    magy = req.num_y[kmc_pkg::SUM_W-1] ? MW'(-req.num_y) : MW'(req.num_y);
  end

  // one trial subtraction per cycle per axis
  always_comb begin
    tx = {rx_r, qx_r[MW-1]};
    ty = {ry_r, qy_r[MW-1]};
    dx = tx - {1'b0, den_r};
    dy = ty - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      qx_r   <= magx;
      qy_r   <= magy;
      rx_r   <= '0;
      ry_r   <= '0;
      den_r  <= req.den;
      negx_r <= req.num_x[kmc_pkg::SUM_W-1];
      negy_r <= req.num_y[kmc_pkg::SUM_W-1];
    end else if (run_r) begin
      if (!dx[DW]) begin
        rx_r <= dx[DW-1:0];
        qx_r <= {qx_r[MW-2:0], 1'b1};
      end else begin
        rx_r <= tx[DW-1:0];
        qx_r <= {qx_r[MW-2:0], 1'b0};
      end
      if (!dy[DW]) begin
        ry_r <= dy[DW-1:0];
        qy_r <= {qy_r[MW-2:0], 1'b1};
      end else begin
        ry_r <= ty[DW-1:0];
        qy_r <= {qy_r[MW-2:0], 1'b0};
      end
    end
  end

  // apply signs
  always_comb begin
    outx     = negx_r ? -qx_r : qx_r;
    outy     = negy_r ? -qy_r : qy_r;
    rsp.done = done_r;
    rsp.q_x  = outx[kmc_pkg::COORD_W-1:0];
    rsp.q_y  = outy[kmc_pkg::COORD_W-1:0];
  end
endmodule
`default_nettype wire

/* rtl/kmeans_clustering_2d.sv */
// top level of the 2-D Lloyd k-means clustering block
//
//  channel  direction  contents
//  in_      input      point_x, point_y, last_point
//  out_     output     cluster_index, centroid_x, centroid_y, member_count, flags
//  cfg_     input      cluster_count (0), max_rounds (1)
//
// loading takes one point word per cycle into the point memory.
// a run seeds groups over the n points, then per round sums the points,
// divides each non-empty cluster in the shared divider and runs the distance
// search, one centroid per cycle; then k result words.
// reset is synchronous; memories need no clearing, centroids reset to zero.
// the output register lets the next data set load while the last word waits.
`default_nettype none
module kmeans_clustering_2d (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [kmc_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [kmc_pkg::COORD_W-1:0] in_point_y,
  input  wire logic                               in_last_point,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [kmc_pkg::CL_AW-1:0]               out_cluster_index,
  output logic signed [kmc_pkg::COORD_W-1:0]      out_centroid_x,
  output logic signed [kmc_pkg::COORD_W-1:0]      out_centroid_y,
  output logic [kmc_pkg::CNT_W-1:0]               out_member_count,
  output logic                                    out_round_limit_hit,
  output logic                                    out_last_cluster,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [kmc_pkg::CFG_W-1:0]          cfg_data
);
  localparam int CW  = kmc_pkg::COORD_W;
  localparam int AW  = kmc_pkg::PT_AW;
  localparam int NW  = kmc_pkg::CNT_W;
  localparam int GW  = kmc_pkg::CL_AW;
  localparam int KW  = kmc_pkg::K_W;
  localparam int SW  = kmc_pkg::SUM_W;
  localparam int QW  = kmc_pkg::SQ_W;
  localparam int DW  = kmc_pkg::DIST_W;
  localparam int RW  = kmc_pkg::RND_W;
  localparam int NC  = kmc_pkg::MAX_CLUSTERS;

  typedef enum logic [10:0] {
    S_LOAD     = 11'b00000000001,
    S_INIT     = 11'b00000000010,
    S_ACC      = 11'b00000000100,
    S_ACC_TAIL = 11'b00000001000,
    S_DIV_SEL  = 11'b00000010000,
    S_DIV_WAIT = 11'b00000100000,
    S_ASN_RD   = 11'b00001000000,
    S_ASN_RUN  = 11'b00010000000,
    S_ASN_CMP  = 11'b00100000000,
    S_RND_END  = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_t;

  state_t state_r;

  // configuration
  logic [KW-1:0] cfg_k_r;
  logic [RW-1:0] cfg_rounds_r;
  logic [KW-1:0] k_r;
  logic [RW-1:0] rounds_r;

  // counters
  logic [NW-1:0] n_r;
  logic [AW-1:0] j_r;
  logic [GW-1:0] jm_r, ci_r, di_r, oi_r;
  logic [NW-1:0] changed_r;
  logic [RW-1:0] rnd_r;
  logic          hit_r;

  // cluster state
  logic signed [CW-1:0] cen_x_r [NC];
  logic signed [CW-1:0] cen_y_r [NC];
  logic signed [SW-1:0] sum_x_r [NC];
  logic signed [SW-1:0] sum_y_r [NC];
  logic [NW-1:0]        size_r  [NC];
  logic [NW-1:0]        fin_r   [NC];

  // memories
  logic [2*CW-1:0] pt_mem [kmc_pkg::MAX_POINTS];
  logic [GW-1:0]   grp_mem [kmc_pkg::MAX_POINTS];
  logic [2*CW-1:0] pt_q;
  logic [GW-1:0]   grp_q;
  logic            rd_en, pt_we, grp_we;
  logic [AW-1:0]   rd_addr, grp_waddr;
  logic [GW-1:0]   grp_wdata;

  // distance pipeline
  logic [QW-1:0]  sqx_r, sqy_r;
  logic [GW-1:0]  sq_idx_r;
  logic           sq_vld_r;
  logic [DW-1:0]  best_d_r, dist_sum;
  logic [GW-1:0]  best_i_r, best_i_nxt;
  logic           take;
  logic signed [CW:0]     ddx, ddy;
  logic signed [2*CW+1:0] pdx, pdy;

  logic          acc_vld_r;
  logic          in_acc, last_j;
  logic [NW-1:0] limit;
  logic [KW-1:0] k_eff;
  logic [RW-1:0] rounds_eff;
  logic          more;

  kmc_pkg::div_req_t div_req;
  kmc_pkg::div_rsp_t div_rsp;

  kmc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r      <= KW'(2);
      cfg_rounds_r <= RW'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmc_pkg::CFG_CLUSTER_COUNT: cfg_k_r      <= cfg_data[KW-1:0];
        kmc_pkg::CFG_MAX_ROUNDS:    cfg_rounds_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // clamped run settings
  always_comb begin
    if (cfg_k_r == '0) k_eff = KW'(1);
    else if (cfg_k_r > KW'(NC)) k_eff = KW'(NC);
    else k_eff = cfg_k_r;
    rounds_eff = (cfg_rounds_r == '0) ? RW'(1) : cfg_rounds_r;
    limit      = n_r >> kmc_pkg::CHANGE_SHIFT;
    last_j     = ({1'b0, j_r} == n_r - 1'b1);
    in_ready   = (state_r == S_LOAD);
    in_acc     = in_valid && in_ready;
    more       = (changed_r > limit) && ({1'b0, rnd_r} + 1'b1 < {1'b0, rounds_r});
  end

  // memory control
  always_comb begin
    pt_we     = in_acc && (n_r < NW'(kmc_pkg::MAX_POINTS));
    rd_en     = (state_r == S_ACC) || (state_r == S_ASN_RD);
    rd_addr   = j_r;
    grp_we    = (state_r == S_INIT) || (state_r == S_ASN_CMP);
    grp_waddr = j_r;
    grp_wdata = (state_r == S_INIT) ? jm_r : best_i_nxt;
  end

  // point memory
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[n_r[AW-1:0]] <= {in_point_x, in_point_y};
    if (rd_en) pt_q <= pt_mem[rd_addr];
  end

  // group memory
  always_ff @(posedge clk) begin
    if (grp_we) grp_mem[grp_waddr] <= grp_wdata;
    if (rd_en) grp_q <= grp_mem[rd_addr];
  end

  // squared distance of the held point to centroid ci
  always_comb begin
    ddx = {pt_q[2*CW-1], pt_q[2*CW-1:CW]} - {cen_x_r[ci_r][CW-1], cen_x_r[ci_r]};
    ddy = {pt_q[CW-1], pt_q[CW-1:0]} - {cen_y_r[ci_r][CW-1], cen_y_r[ci_r]};
    pdx = ddx * ddx;
    pdy = ddy * ddy;
    dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    take = sq_vld_r && ((sq_idx_r == '0) || (dist_sum < best_d_r));
    best_i_nxt = take ? sq_idx_r : best_i_r;
  end

  always_ff @(posedge clk) begin
    sqx_r    <= pdx[QW-1:0];
    sqy_r    <= pdy[QW-1:0];
    sq_idx_r <= ci_r;
    if (take) begin
      best_d_r <= dist_sum;
      best_i_r <= sq_idx_r;
    end
  end

  // divider request
  always_comb begin
    div_req.start = (state_r == S_DIV_SEL) && (size_r[di_r] != '0);
    div_req.num_x = sum_x_r[di_r];
    div_req.num_y = sum_y_r[di_r];
    div_req.den   = size_r[di_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      n_r       <= '0;
      j_r       <= '0;
      jm_r      <= '0;
      ci_r      <= '0;
      di_r      <= '0;
      oi_r      <= '0;
      k_r       <= KW'(1);
      rounds_r  <= RW'(1);
      changed_r <= '0;
      rnd_r     <= '0;
      hit_r     <= 1'b0;
      sq_vld_r  <= 1'b0;
      acc_vld_r <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cen_x_r[i] <= '0;
        cen_y_r[i] <= '0;
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        size_r[i]  <= '0;
        fin_r[i]   <= '0;
      end
    end else begin
      sq_vld_r  <= (state_r == S_ASN_RUN);
      acc_vld_r <= (state_r == S_ACC);
      // outside the result phase a taken word empties the output register
      if (out_valid && out_ready && (state_r != S_OUT)) out_valid <= 1'b0;

      // accumulate point words from the memory read
      if (acc_vld_r) begin
        sum_x_r[grp_q] <= sum_x_r[grp_q] + SW'(signed'(pt_q[2*CW-1:CW]));
        sum_y_r[grp_q] <= sum_y_r[grp_q] + SW'(signed'(pt_q[CW-1:0]));
        size_r[grp_q]  <= size_r[grp_q] + 1'b1;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (pt_we) n_r <= n_r + 1'b1;
            if (in_last_point) begin
              k_r      <= k_eff;
              rounds_r <= rounds_eff;
              j_r      <= '0;
              jm_r     <= '0;
              rnd_r    <= '0;
              state_r  <= S_INIT;
            end
          end
        end
        S_INIT: begin
          jm_r <= ({1'b0, jm_r} == k_r - 1'b1) ? '0 : jm_r + 1'b1;
          if (last_j) begin
            j_r <= '0;
            for (int i = 0; i < NC; i++) begin
              sum_x_r[i] <= '0;
              sum_y_r[i] <= '0;
              size_r[i]  <= '0;
            end
            state_r <= S_ACC;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_ACC: begin
          j_r <= j_r + 1'b1;
          if (last_j) state_r <= S_ACC_TAIL;
        end
        S_ACC_TAIL: begin
          di_r    <= '0;
          state_r <= S_DIV_SEL;
        end
        S_DIV_SEL: begin
          if (size_r[di_r] != '0) begin
            state_r <= S_DIV_WAIT;
          end else if ({1'b0, di_r} == k_r - 1'b1) begin
            j_r       <= '0;
            changed_r <= '0;
            for (int i = 0; i < NC; i++) fin_r[i] <= '0;
            state_r <= S_ASN_RD;
          end else begin
            di_r <= di_r + 1'b1;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            cen_x_r[di_r] <= div_rsp.q_x;
            cen_y_r[di_r] <= div_rsp.q_y;
            if ({1'b0, di_r} == k_r - 1'b1) begin
              j_r       <= '0;
              changed_r <= '0;
              for (int i = 0; i < NC; i++) fin_r[i] <= '0;
              state_r <= S_ASN_RD;
            end else begin
              di_r    <= di_r + 1'b1;
              state_r <= S_DIV_SEL;
            end
          end
        end
        S_ASN_RD: begin
          ci_r    <= '0;
          state_r <= S_ASN_RUN;
        end
        S_ASN_RUN: begin
          ci_r <= ci_r + 1'b1;
          if ({1'b0, ci_r} == k_r - 1'b1) state_r <= S_ASN_CMP;
        end
        S_ASN_CMP: begin
          ci_r <= '0;
          fin_r[best_i_nxt] <= fin_r[best_i_nxt] + 1'b1;
          if (best_i_nxt != grp_q) changed_r <= changed_r + 1'b1;
          if (last_j) begin
            state_r <= S_RND_END;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ASN_RD;
          end
        end
        S_RND_END: begin
          rnd_r <= rnd_r + 1'b1;
          j_r   <= '0;
          if (more) begin
            for (int i = 0; i < NC; i++) begin
              sum_x_r[i] <= '0;
              sum_y_r[i] <= '0;
              size_r[i]  <= '0;
            end
            state_r <= S_ACC;
          end else begin
            hit_r   <= (changed_r > limit);
            oi_r    <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_cluster_index   <= oi_r;
            out_centroid_x      <= cen_x_r[oi_r];
            out_centroid_y      <= cen_y_r[oi_r];
            out_member_count    <= fin_r[oi_r];
            out_round_limit_hit <= hit_r;
            out_last_cluster    <= ({1'b0, oi_r} == k_r - 1'b1);
            oi_r                <= oi_r + 1'b1;
            if ({1'b0, oi_r} == k_r - 1'b1) begin
              n_r     <= '0;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/kmc_checker.sv */
// port-level checker for the k-means clustering block, with its bind
`default_nettype none
`include "assert_macros.svh"
module kmc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_last_point,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [kmc_pkg::CNT_W-1:0]     out_member_count,
  input wire logic signed [kmc_pkg::COORD_W-1:0] out_centroid_x,
  input wire logic                          out_last_cluster
);
  // a stalled result word holds
  `KMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_centroid_x))
  // the final point starts a run, so input closes
  `KMC_ASSERT_NEXT(a_run_blocks, in_valid && in_ready && in_last_point, !in_ready)
  // loading stays closed until the final cluster word is out of the sequencer
  `KMC_ASSERT(a_out_before_load, !(out_valid && !out_last_cluster) || !in_ready)
  // member count never exceeds the point memory
  `KMC_ASSERT(a_count_range, !out_valid || out_member_count <= kmc_pkg::CNT_W'(kmc_pkg::MAX_POINTS))
endmodule

bind kmeans_clustering_2d kmc_checker u_kmc_checker (
  .clk (clk),
  .rst_n (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_last_point (in_last_point),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_member_count (out_member_count),
  .out_centroid_x (out_centroid_x),
  .out_last_cluster (out_last_cluster)
);
`default_nettype wire
